FILE: rtl/polyline_delta_decoder_assert.svh
// Assertion macros shared by the polyline decoder modules.
`ifndef POLYLINE_DELTA_DECODER_ASSERT_SVH
`define POLYLINE_DELTA_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pdd_pkg.sv
package pdd_pkg;

    localparam int PDD_MAX_DIMENSIONS = 8;
    localparam int PDD_MAX_GROUPS     = 7;

    localparam logic [7:0] BIAS        = 8'h3f;
    localparam logic [7:0] CHAR_MAX    = 8'h7f;
    localparam logic [4:0] GROUP_MASK  = 5'h1f;
    localparam int         CONT_BIT    = 5;
    localparam int         GROUP_BITS  = 5;
    localparam int         COORD_W     = 32;
    localparam int         DIM_OUT_W   = 3;

    localparam logic [3:0] TUPLE_SIZE_RST  = 4'd2;
    localparam logic [3:0] TUPLE_SIZE_ZERO = 4'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BADCHAR    = 2'd1,
        ST_TOOLONG    = 2'd2,
        ST_UNFINISHED = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate;
        logic [DIM_OUT_W-1:0]      dimension;
        logic                      point_complete;
        logic                      string_done;
        t_status                   status;
    } t_result;

endpackage

FILE: rtl/pdd_core.sv
`include "polyline_delta_decoder_assert.svh"

module pdd_core
    import pdd_pkg::*;
#(
    parameter int MAX_DIMENSIONS = PDD_MAX_DIMENSIONS,
    parameter int MAX_GROUPS     = PDD_MAX_GROUPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_advance,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic [3:0] i_tuple_size,
    output logic       o_has_result,
    output t_result    o_result
);

    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int CNT_W = $clog2(MAX_GROUPS);
    localparam int ACC_W = GROUP_BITS * MAX_GROUPS;
    localparam int EXT_W = (ACC_W > COORD_W + 1) ? ACC_W : COORD_W + 1;
    localparam int SZ_W  = 5;

    logic [COORD_W-1:0]    r_rv [MAX_DIMENSIONS];
    logic [GROUP_BITS-1:0] r_acc [MAX_GROUPS];
    logic [CNT_W-1:0]      r_count;
    logic [DIM_W-1:0]      r_dim;

    logic [7:0]         w_sub;
    logic [6:0]         w_chunk;
    logic               w_bad;
    logic               w_cont;
    logic               w_too_long;
    logic [ACC_W-1:0]   w_acc_new;
    logic [EXT_W-1:0]   w_acc_ext;
    logic [COORD_W-1:0] w_mag;
    logic [COORD_W-1:0] w_delta;
    logic [COORD_W-1:0] w_sum;
    logic [SZ_W-1:0]    w_size;
    logic [SZ_W-1:0]    w_dim_inc;
    logic               w_done;
    logic [DIM_W+2:0]   w_dim_ext;
    logic               w_finish;
    logic               w_clr_all;
    logic               w_clr_acc;
    logic [CNT_W-1:0]   n_count;
    logic [DIM_W-1:0]   n_dim;

    always_comb begin
        w_sub      = i_char - BIAS;
        w_chunk    = w_sub[6:0];
        w_bad      = (i_char < BIAS) || (i_char > CHAR_MAX);
        w_cont     = w_chunk[CONT_BIT];
        w_too_long = w_cont && (r_count == CNT_W'(MAX_GROUPS - 1));

        for (int g = 0; g < MAX_GROUPS; g++) begin
            w_acc_new[g*GROUP_BITS +: GROUP_BITS] = r_acc[g];
            if (r_count == CNT_W'(g)) begin
                w_acc_new[g*GROUP_BITS +: GROUP_BITS] = r_acc[g] | (w_chunk[4:0] & GROUP_MASK);
            end
        end

        // Zigzag decode: odd values are negative.
        w_acc_ext = EXT_W'(w_acc_new);
        w_mag     = w_acc_ext[COORD_W:1];
        w_delta   = w_acc_new[0] ? ~w_mag : w_mag;
        w_sum     = r_rv[r_dim] + w_delta;

        w_size = SZ_W'(i_tuple_size);
        if (i_tuple_size == 4'd0) begin
            w_size = SZ_W'(TUPLE_SIZE_ZERO);
        end
        if (w_size > SZ_W'(MAX_DIMENSIONS)) begin
            w_size = SZ_W'(MAX_DIMENSIONS);
        end
        w_dim_inc = SZ_W'(r_dim) + SZ_W'(1);
        w_done    = (w_dim_inc >= w_size);
        w_dim_ext = (DIM_W + 3)'(r_dim);

        w_finish  = !w_bad && !w_cont;
        w_clr_all = i_last;
        w_clr_acc = w_bad || w_too_long || w_finish;

        n_count = r_count;
        n_dim   = r_dim;
        if (w_clr_acc) begin
            n_count = '0;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
        if (w_finish) begin
            n_dim = w_done ? '0 : w_dim_inc[DIM_W-1:0];
        end

        o_has_result                = w_bad || w_too_long || w_finish || i_last;
        o_result.coordinate         = '0;
        o_result.dimension          = w_dim_ext[DIM_OUT_W-1:0];
        o_result.point_complete     = 1'b0;
        o_result.string_done        = i_last;
        o_result.status             = ST_UNFINISHED;
        if (w_bad) begin
            o_result.status = ST_BADCHAR;
        end else if (w_too_long) begin
            o_result.status = ST_TOOLONG;
        end else if (w_finish) begin
            o_result.coordinate     = w_sum;
            o_result.point_complete = w_done;
            o_result.status         = (i_last && !w_done) ? ST_UNFINISHED : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dim   <= '0;
            for (int d = 0; d < MAX_DIMENSIONS; d++) begin
                r_rv[d] <= '0;
            end
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_acc[g] <= '0;
            end
        end else if (i_advance) begin
            if (w_clr_all) begin
                r_count <= '0;
                r_dim   <= '0;
                for (int d = 0; d < MAX_DIMENSIONS; d++) begin
                    r_rv[d] <= '0;
                end
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    r_acc[g] <= '0;
                end
            end else begin
                r_count <= n_count;
                r_dim   <= n_dim;
                if (w_finish) begin
                    r_rv[r_dim] <= w_sum;
                end
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    if (w_clr_acc) begin
                        r_acc[g] <= '0;
                    end else begin
                        r_acc[g] <= w_acc_new[g*GROUP_BITS +: GROUP_BITS];
                    end
                end
            end
        end
    end

    `PDD_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_GROUPS - 1), "Group count passed the longest value.")
    `PDD_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, i_advance && i_last, (r_count == '0) && (r_dim == '0), "State not cleared after end of string.")
    `PDD_ASSERT_IMP(a_last_has_result, i_clk, i_rst_n, i_valid && i_last, o_has_result, "Final character produced no result.")

endmodule

FILE: rtl/polyline_delta_decoder.sv
// Encoded polyline decoder. Each stream transaction carries one character of the
// encoded string, with tlast on its final character. A character is taken into an
// input register, decoded from there against the group accumulator and the running
// value of its tuple dimension, and its result, if any, is registered in the output
// register. One character is taken every cycle while s_axis_tready is high;
// s_axis_tready falls only while the output register holds a result that is not
// taken and the held character would produce another. Results carry the running
// coordinate (32-bit, wrapping), its dimension, a point-complete flag and a status
// in tuser. After the final character all decoding state returns to zero.
// tuple_size may be written only while idle.

`include "polyline_delta_decoder_assert.svh"

module polyline_delta_decoder
    import pdd_pkg::*;
#(
    parameter int MAX_DIMENSIONS = PDD_MAX_DIMENSIONS,
    parameter int MAX_GROUPS     = PDD_MAX_GROUPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] coordinate, [34:32] dimension,
                                        // [35] point_complete, [39:36] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;
    logic       r_out_valid;
    t_result    r_out;
    logic [3:0] r_tuple_size;

    logic       w_has_result;
    t_result    w_result;
    logic       w_out_free;
    logic       w_advance;
    logic       w_cfg_wr;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_s1_valid && (!w_has_result || w_out_free);
    assign s_axis_tready = !r_s1_valid || w_advance;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {28'd0, r_tuple_size} : 32'd0;

    pdd_core #(
        .MAX_DIMENSIONS(MAX_DIMENSIONS),
        .MAX_GROUPS    (MAX_GROUPS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_advance   (w_advance),
        .i_char      (r_s1_char),
        .i_last      (r_s1_last),
        .i_tuple_size(r_tuple_size),
        .o_has_result(w_has_result),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuple_size <= TUPLE_SIZE_RST;
        end else if (w_cfg_wr) begin
            r_tuple_size <= pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_char <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.point_complete, r_out.dimension, r_out.coordinate};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.string_done;

    `PDD_ASSERT_IMP(a_ready_low, i_clk, i_rst_n, !s_axis_tready, r_s1_valid && r_out_valid && !m_axis_tready, "Input stalled without a blocked result.")
    `PDD_ASSERT_IMP(a_point_ok, i_clk, i_rst_n, r_out_valid && r_out.point_complete, r_out.status == ST_OK, "Completed point carries an error status.")
    `PDD_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, r_out_valid && ((r_out.status == ST_BADCHAR) || (r_out.status == ST_TOOLONG)), (r_out.coordinate == '0) && !r_out.point_complete, "Error result carries a coordinate.")

endmodule

FILE: bench/polyline_delta_decoder_checker.sv
`timescale 1ns / 1ps

module polyline_delta_decoder_checker
    import pdd_pkg::*;
#(
    parameter logic [2:0] REG_TUPLE_SIZE = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,

    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,

    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    logic [COORD_W-1:0]              running [PDD_MAX_DIMENSIONS];
    logic [GROUP_BITS*PDD_MAX_GROUPS-1:0] group_acc;
    int unsigned                     group_cnt;
    int unsigned                     cur_dim;
    logic [3:0]                      tuple_size;
    t_result                         decoded_q[$];
    int                              errors = 0;
    int                              results = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    function automatic void clear_stream();
        for (int d = 0; d < PDD_MAX_DIMENSIONS; d++) begin
            running[d] = '0;
        end
        group_acc = '0;
        group_cnt = 0;
        cur_dim   = 0;
    endfunction

    // Returns 1 when the character produces a result, which is placed in res.
    function automatic bit decode_char(input logic [7:0] ch, input logic eos,
                                       output t_result res);
        logic [7:0]                           chunk;
        logic [GROUP_BITS*PDD_MAX_GROUPS-1:0] piece;
        int unsigned                          size;
        int unsigned                          dim;
        logic [COORD_W-1:0]                   delta;
        logic [COORD_W-1:0]                   value;
        logic                                 done;
        size = (tuple_size == 4'd0) ? TUPLE_SIZE_ZERO : tuple_size;
        if (size > PDD_MAX_DIMENSIONS) begin
            size = PDD_MAX_DIMENSIONS;
        end
        dim = cur_dim % PDD_MAX_DIMENSIONS;
        res = '0;
        res.dimension   = DIM_OUT_W'(dim);
        res.string_done = eos;
        res.status      = ST_OK;
        if (ch < BIAS || ch > CHAR_MAX) begin
            group_acc  = '0;
            group_cnt  = 0;
            res.status = ST_BADCHAR;
            if (eos) begin
                clear_stream();
            end
            return 1'b1;
        end
        chunk = ch - BIAS;
        if (group_cnt < PDD_MAX_GROUPS) begin
            piece = chunk & GROUP_MASK;
            group_acc |= piece << (GROUP_BITS * group_cnt);
        end
        if (chunk[CONT_BIT]) begin
            group_cnt++;
            if (group_cnt >= PDD_MAX_GROUPS) begin
                group_acc  = '0;
                group_cnt  = 0;
                res.status = ST_TOOLONG;
                if (eos) begin
                    clear_stream();
                end
                return 1'b1;
            end
            if (eos) begin
                res.status = ST_UNFINISHED;
                clear_stream();
                return 1'b1;
            end
            return 1'b0;
        end
        // Undo the zigzag sign: odd accumulators are negative.
        delta = group_acc[COORD_W:1];
        if (group_acc[0]) begin
            delta = ~delta;
        end
        group_acc = '0;
        group_cnt = 0;
        value = running[dim] + delta;
        running[dim] = value;
        done = (dim + 1 >= size);
        cur_dim = done ? 0 : dim + 1;
        res.coordinate     = value;
        res.point_complete = done;
        if (eos && !done) begin
            res.status = ST_UNFINISHED;
        end
        if (eos) begin
            clear_stream();
        end
        return 1'b1;
    endfunction

    task automatic report_result(input string what, input t_result want, input t_result got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch at %0t ns: %s", $time, what);
            $display("  expected: coord %0d dim %0d complete %0b done %0b status %0d",
                     want.coordinate, want.dimension, want.point_complete,
                     want.string_done, want.status);
            $display("  actual:   coord %0d dim %0d complete %0b done %0b status %0d",
                     got.coordinate, got.dimension, got.point_complete,
                     got.string_done, got.status);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_stream();
            tuple_size = TUPLE_SIZE_RST;
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.coordinate     = i_m_tdata[31:0];
                got.dimension      = i_m_tdata[34:32];
                got.point_complete = i_m_tdata[35];
                got.string_done    = i_m_tlast;
                got.status         = t_status'(i_m_tuser);
                results++;
                if (decoded_q.size() == 0) begin
                    report_result("result with none outstanding", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        report_result("field differs", want, got);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (decode_char(i_s_tdata, i_s_tlast, want)) begin
                    decoded_q.push_back(want);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_TUPLE_SIZE) begin
                tuple_size = i_pwdata[3:0];
            end
        end
        o_errors  <= errors;
        o_pending <= decoded_q.size();
        o_results <= results;
    end

endmodule

FILE: bench/polyline_delta_decoder_tb.sv
`timescale 1ns / 1ps

module polyline_delta_decoder_tb;
    import pdd_pkg::*;

    localparam logic [2:0] REG_TUPLE_SIZE  = 3'd0;
    localparam int         SETTING_COUNT   = 8;
    localparam int         CHARS_PER_PHASE = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_count;
    int          result_count;

    logic [8:0]  text_q[$];
    int          sent = 0;
    int          settings_used = 0;
    bit          calm = 1'b0;

    polyline_delta_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    polyline_delta_decoder_checker #(
        .REG_TUPLE_SIZE (REG_TUPLE_SIZE)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (mismatch_count),
        .o_pending  (pending_count),
        .o_results  (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial begin : sink
        int run_len;
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 8);
            stall = pick_gap(1'b0);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eos);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text();
        logic [8:0] entry;
        while (text_q.size() > 0) begin
            entry = text_q.pop_front();
            send_char(entry[7:0], entry[8]);
        end
    endtask

    task automatic add_char(input logic [7:0] ch, input logic eos);
        text_q.push_back({eos, ch});
    endtask

    // Waits for every outstanding result, then for a character still in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_tuple_size(input logic [3:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TUPLE_SIZE;
        pwdata  <= {28'($urandom()), size};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic add_value();
        logic [31:0] v;
        logic [31:0] zz;
        logic [34:0] groups;
        logic        cont;
        int          n;
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, PDD_MAX_GROUPS);
            groups = 35'({$urandom(), $urandom()});
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                v = $urandom();
            end else begin
                v = $urandom_range(0, 3000) - 1500;
            end
            zz = {v[30:0], 1'b0} ^ {32{v[31]}};
            groups = {3'b000, zz};
            n = 1;
            while (n < PDD_MAX_GROUPS && (groups >> (GROUP_BITS * n)) != 0) n++;
        end
        for (int g = 0; g < n; g++) begin
            cont = (g < n - 1);
            text_q.push_back({1'b0, BIAS + {2'b00, cont, groups[GROUP_BITS*g +: 5]}});
        end
    endtask

    task automatic add_noise();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: begin
                if ($urandom_range(0, 1) == 1) begin
                    add_char(8'($urandom_range(0, 62)), 1'b0);
                end else begin
                    add_char(8'($urandom_range(128, 255)), 1'b0);
                end
            end
            1: begin
                repeat ($urandom_range(7, 9)) begin
                    add_char(BIAS + (8'd1 << CONT_BIT) + 8'($urandom_range(0, 31)), 1'b0);
                end
            end
            2: begin
                add_char(8'($urandom()), 1'b0);
            end
            default: begin
                add_char(CHAR_MAX, 1'b0);
            end
        endcase
    endtask

    task automatic add_string(input int dims);
        int         nvals;
        int         ending;
        logic [8:0] tail;
        nvals = $urandom_range(1, 3 * dims);
        for (int i = 0; i < nvals; i++) begin
            if ($urandom_range(0, 99) < 88) begin
                add_value();
            end else begin
                add_noise();
            end
        end
        ending = $urandom_range(0, 9);
        case (ending)
            0: add_char(BIAS + (8'd1 << CONT_BIT) + 8'($urandom_range(0, 31)), 1'b0);
            1: add_value();
            2: add_char(8'($urandom_range(0, 62)), 1'b0);
            default: ;
        endcase
        tail = text_q.pop_back();
        tail[8] = 1'b1;
        text_q.push_back(tail);
        send_text();
    endtask

    initial begin : stimulus
        logic [3:0] size;
        int         dims;
        int         target;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero deltas, field extremes, bad characters on both sides of the
        // valid range, the widest value, and every way a string can end.
        add_char(8'h3f, 1'b0);
        add_char(8'h7f, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'h3e, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'hff, 1'b0);
        repeat (6) add_char(8'h7e, 1'b0);
        add_char(8'h5e, 1'b0);
        add_char(8'h40, 1'b1);
        repeat (6) add_char(8'h5f, 1'b0);
        add_char(8'h5f, 1'b1);
        add_char(8'h5f, 1'b1);
        add_char(8'h41, 1'b1);
        add_char(8'h20, 1'b1);
        send_text();

        for (int phase = 0; phase < SETTING_COUNT; phase++) begin
            settle();
            case (phase)
                0: size = 4'd1;
                1: size = 4'd8;
                2: size = 4'd0;
                3: size = 4'd15;
                4: size = 4'd3;
                5: size = 4'd9;
                default: size = 4'($urandom_range(1, 8));
            endcase
            write_tuple_size(size);
            dims = (size == 4'd0) ? 2 : ((size > 4'd8) ? 8 : size);
            target = sent + CHARS_PER_PHASE;
            while (sent < target) begin
                calm = ($urandom_range(0, 4) == 0);
                add_string(dims);
            end
            calm = 1'b0;
            // Leave a tuple open so the next setting takes effect mid tuple.
            add_value();
            send_text();
        end

        settle();
        $display("Sent %0d characters, checked %0d results over %0d tuple-size settings.",
                 sent, result_count, settings_used);
        $display("Bad characters, overlong values and mid-value string ends were included.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
